@@ rtl/adt_pkg.sv @@
// Shared types, register indexes and reset values for the double-tap detector.
package adt_pkg;

   localparam int SensorWidth = 32;
   localparam int AccelWidth  = 16;
   localparam int LevelWidth  = 15;
   localparam int TimerWidth  = 20;
   localparam int TallyWidth  = 3;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 32;

   // item kinds
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_ACCEPTED_SENSOR    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PEAK_THRESHOLD     = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_REFLECTION_MINIMUM = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_REFLECTION_TIMEOUT = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_SECOND_TAP_TIMEOUT = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_TAPS_NEEDED        = 3'd5;

   // register reset values
   localparam logic [SensorWidth-1:0] RST_ACCEPTED_SENSOR    = 32'h1027_3024;
   localparam logic [LevelWidth-1:0]  RST_PEAK_THRESHOLD     = 15'd500;
   localparam logic [LevelWidth-1:0]  RST_REFLECTION_MINIMUM = 15'd20;
   localparam logic [TimerWidth-1:0]  RST_REFLECTION_TIMEOUT = 20'd50000;
   localparam logic [TimerWidth-1:0]  RST_SECOND_TAP_TIMEOUT = 20'd400000;
   localparam logic [TallyWidth-1:0]  RST_TAPS_NEEDED        = 3'd2;

   typedef struct packed {
      logic                          operation;
      logic [SensorWidth-1:0]        sensor_id;
      logic signed [AccelWidth-1:0]  accel_value;
   } req_type;

   typedef struct packed {
      logic skip;
      logic tap_seen;
   } rsp_type;

   typedef struct packed {
      logic [SensorWidth-1:0] accepted_sensor;
      logic [LevelWidth-1:0]  peak_threshold;
      logic [LevelWidth-1:0]  reflection_minimum;
      logic [TimerWidth-1:0]  reflection_timeout;
      logic [TimerWidth-1:0]  second_tap_timeout;
      logic [TallyWidth-1:0]  taps_needed;
   } cfg_type;

endpackage

@@ rtl/accel_double_tap_detector.sv @@
// Top level of the accelerometer double-tap detector: input and result registers.
//
//  port group  direction  flow control     word
//  req_        in         valid / stall    adt_pkg::req_type (operation, sensor_id, accel_value)
//  rsp_        out        valid / stall    adt_pkg::rsp_type (skip, tap_seen)
//  csr_        in         valid / ready    index 0..5, 32-bit write data
//
// One word per cycle while rsp_stall is low; words pass the input, then the result register.
// Each word is processed in the cycle it leaves the input register, one compare-and-count
// pass against the tap state, and lands in the result register.
// Synchronous reset clears the tap state, both valid flags and the registers to defaults.
// rsp_stall holds the result register; a new word still enters while the input register
// is empty or draining, and req_stall rises only when both registers hold words.
// csr_ready is always high.
module accel_double_tap_detector (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  adt_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output adt_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [adt_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [adt_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import adt_pkg::*;

   cfg_type cfg;
   req_type in_data_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type result;
   logic    out_free;
   logic    advance;
   logic    take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   adt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   adt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ rtl/adt_csr.sv @@
// Configuration register file for the double-tap detector.
module adt_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [adt_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [adt_pkg::CsrDataWidth-1:0]       csr_wdata,
   output adt_pkg::cfg_type                       cfg
);
   import adt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ACCEPTED_SENSOR:    cfg_in.accepted_sensor    = csr_wdata;
            CSR_PEAK_THRESHOLD:     cfg_in.peak_threshold     = csr_wdata[LevelWidth-1:0];
            CSR_REFLECTION_MINIMUM: cfg_in.reflection_minimum = csr_wdata[LevelWidth-1:0];
            CSR_REFLECTION_TIMEOUT: cfg_in.reflection_timeout = csr_wdata[TimerWidth-1:0];
            CSR_SECOND_TAP_TIMEOUT: cfg_in.second_tap_timeout = csr_wdata[TimerWidth-1:0];
            CSR_TAPS_NEEDED:        cfg_in.taps_needed        = csr_wdata[TallyWidth-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accepted_sensor    <= RST_ACCEPTED_SENSOR;
         cfg_ff.peak_threshold     <= RST_PEAK_THRESHOLD;
         cfg_ff.reflection_minimum <= RST_REFLECTION_MINIMUM;
         cfg_ff.reflection_timeout <= RST_REFLECTION_TIMEOUT;
         cfg_ff.second_tap_timeout <= RST_SECOND_TAP_TIMEOUT;
         cfg_ff.taps_needed        <= RST_TAPS_NEEDED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/adt_core.sv @@
// Tap state (peak, tally, timer) and the per-word update logic.
module adt_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  adt_pkg::req_type    item,
   input  adt_pkg::cfg_type    cfg,
   output adt_pkg::rsp_type    result
);
   import adt_pkg::*;

   logic signed [AccelWidth-1:0] peak_ff, peak_in;
   logic [TallyWidth-1:0]        tally_ff, tally_in;
   logic [TimerWidth-1:0]        left_ff, left_in;
   logic                         armed_ff, armed_in;

   logic [AccelWidth-1:0] mag;
   logic                  is_peak;
   logic                  is_refl;
   logic                  mine;
   logic [TallyWidth-1:0] tally_inc;

   // magnitude of the most negative value is 32768, still fits 16 bits unsigned
   assign mag = item.accel_value[AccelWidth-1] ? AccelWidth'(-item.accel_value)
                                               : item.accel_value;
   assign mine    = (item.operation == OP_SAMPLE) && (item.sensor_id == cfg.accepted_sensor);
   assign is_peak = mag >= {1'b0, cfg.peak_threshold};
   assign is_refl = !is_peak && (peak_ff != '0) && (item.accel_value != '0)
                    && (peak_ff[AccelWidth-1] != item.accel_value[AccelWidth-1])
                    && (mag >= {1'b0, cfg.reflection_minimum});
   assign tally_inc = tally_ff + TallyWidth'(1);

   always_comb begin
      peak_in         = peak_ff;
      tally_in        = tally_ff;
      left_in         = left_ff;
      armed_in        = armed_ff;
      result.skip     = 1'b0;
      result.tap_seen = 1'b0;
      if (item.operation == OP_TICK) begin
         if (armed_ff) begin
            if (left_ff <= TimerWidth'(1)) begin
               left_in  = '0;
               armed_in = 1'b0;
               peak_in  = '0;
               tally_in = '0;
            end else begin
               left_in = left_ff - TimerWidth'(1);
            end
         end
      end else if (mine) begin
         if (is_peak) begin
            peak_in  = item.accel_value;
            left_in  = cfg.reflection_timeout;
            armed_in = 1'b1;
         end else if (is_refl) begin
            result.tap_seen = 1'b1;
            peak_in = '0;
            if (tally_inc == cfg.taps_needed) begin
               result.skip = 1'b1;
               tally_in    = '0;
               left_in     = '0;
               armed_in    = 1'b0;
            end else begin
               tally_in = tally_inc;
               left_in  = cfg.second_tap_timeout;
               armed_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff  <= '0;
         tally_ff <= '0;
         left_ff  <= '0;
         armed_ff <= 1'b0;
      end else if (step) begin
         peak_ff  <= peak_in;
         tally_ff <= tally_in;
         left_ff  <= left_in;
         armed_ff <= armed_in;
      end
   end

   a_skip_is_tap: assert property (@(posedge clock) disable iff (reset)
      result.skip |-> result.tap_seen)
      else $error("skip without tap");

   a_stopped_timer_empty: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (left_ff == '0))
      else $error("stopped timer holds ticks");

   a_expiry_clears: assert property (@(posedge clock) disable iff (reset)
      (step && item.operation == OP_TICK && armed_ff && left_ff <= TimerWidth'(1))
      |=> (peak_ff == '0 && tally_ff == '0 && !armed_ff))
      else $error("timeout did not clear state");

   a_tap_clears_peak: assert property (@(posedge clock) disable iff (reset)
      (step && result.tap_seen) |=> (peak_ff == '0))
      else $error("tap left a stored peak");

endmodule
